// ===== sv/gcsp_pkg.sv =====
// Shared types, codes and constants for the game controller serial ports.
// No dependencies; imported by game_controller_serial_ports.
package gcsp_pkg;

    // Serial word length and the counter that walks it
    localparam int SERIAL_BITS = 24;
    localparam int CNT_W       = $clog2(SERIAL_BITS + 1);
    localparam int IDX_W       = $clog2(SERIAL_BITS);
    // Bits 19..0 carry pad data and the extension signatures
    localparam int BASE_W      = 20;

    localparam logic [7:0] READ_BASE     = 8'h40;
    localparam logic [7:0] PADDLE_OFFSET = 8'h52;
    localparam logic [7:0] PADDLE_INVERT = 8'hff;
    localparam logic [8:0] BRIGHT_A      = 9'h020;
    localparam logic [8:0] BRIGHT_B      = 9'h030;
    localparam logic [8:0] BRIGHT_C      = 9'h033;
    localparam logic [8:0] BRIGHT_D      = 9'h034;
    localparam int         LIGHT_BIT     = 3;
    localparam int         TRIGGER_BIT   = 4;
    localparam int         SIG_ZERO_BIT  = 19;
    localparam int         SIG_ONE_BIT   = 18;

    typedef logic [SERIAL_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]       t_count;

    // Request codes
    localparam logic [1:0] REQ_READ_ZERO = 2'd0;
    localparam logic [1:0] REQ_READ_ONE  = 2'd1;
    localparam logic [1:0] REQ_STROBE    = 2'd2;

    // Device codes of a device_select nibble
    localparam logic [3:0] DEV_NONE    = 4'd0;
    localparam logic [3:0] DEV_PAD     = 4'd1;
    localparam logic [3:0] DEV_GUN_ONE = 4'd2;
    localparam logic [3:0] DEV_GUN_TWO = 4'd3;
    localparam logic [3:0] DEV_PADDLE  = 4'd4;

    // Configuration register indexes
    localparam logic CFG_DEVICE_SELECT = 1'b0;
    localparam logic CFG_PALETTE_BASE  = 1'b1;

    // What a strobe latches for one port
    typedef struct packed {
        logic [BASE_W-1:0] word;
        logic [7:0]        gun_x;
        logic [7:0]        gun_y;
    } t_latch;

endpackage

// ===== sv/game_controller_serial_ports.sv =====
// Game controller serial ports: two ports with a shared strobe, plus config.
// Depends on gcsp_pkg.
//
// Takes one bus transfer per clock. A strobe write with bit0 clear resets
// both bit counters and latches a serial word and a gun position per port;
// a port read returns 0x40 with the next serial bit (and light-gun bits in
// gun mode) in the next cycle through a single output register. Strobe writes
// and request code 3 give no result. Throughput is one item per cycle while
// the result side takes transfers; the input stalls only while the output
// register holds a result that the receiver is stalling.
module game_controller_serial_ports
    import gcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_strobe_bit,
    input  logic [31:0] i_pad_buttons,
    input  logic        i_gun_one_trigger,
    input  logic [7:0]  i_gun_one_x,
    input  logic [7:0]  i_gun_one_y,
    input  logic        i_gun_two_trigger,
    input  logic [7:0]  i_gun_two_x,
    input  logic [7:0]  i_gun_two_y,
    input  logic [7:0]  i_paddle_position,
    input  logic [8:0]  i_pixel_at_gun,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_latched_gun_x,
    output logic [7:0]  o_latched_gun_y
);

    logic [15:0] r_device_select;
    logic [7:0]  r_palette_base;
    t_word       r_serial_zero, r_serial_one;
    t_count      r_count_zero, r_count_one;
    logic [7:0]  r_gun_x_zero, r_gun_y_zero, r_gun_x_one, r_gun_y_one;
    logic        r_out_valid;
    logic [7:0]  r_read_data, r_gun_x, r_gun_y;

    logic        accept;
    logic        is_strobe, is_read_zero, is_read_one;
    t_latch      latch_zero, latch_one;
    t_word       n_serial_zero, n_serial_one;
    logic [3:0]  nib0, nib1, nib2, nib3;
    t_word       sel_word;
    t_count      sel_count, n_count;
    logic        sel_gun, serial_bit, bright;
    logic [8:0]  pal;
    logic [7:0]  n_read_data;

    assign o_in_stall   = r_out_valid & i_out_stall;
    assign accept       = i_in_valid & ~o_in_stall;
    assign is_strobe    = (i_req_type == REQ_STROBE) & ~i_strobe_bit;
    assign is_read_zero = i_req_type == REQ_READ_ZERO;
    assign is_read_one  = i_req_type == REQ_READ_ONE;

    assign nib0 = r_device_select[3:0];
    assign nib1 = r_device_select[7:4];
    assign nib2 = r_device_select[11:8];
    assign nib3 = r_device_select[15:12];

    // Decode one port's device into its latched word and gun position
    function automatic t_latch latch_port(
        input logic [3:0] code,
        input logic [7:0] pad_byte,
        input logic       paddle_ok,
        input logic       g1_trig, input logic [7:0] g1_x, input logic [7:0] g1_y,
        input logic       g2_trig, input logic [7:0] g2_x, input logic [7:0] g2_y,
        input logic [7:0] paddle
    );
        t_latch l;
        logic [7:0] paddle_sum;
        paddle_sum = paddle + PADDLE_OFFSET;
        l = '0;
        unique case (code)
            DEV_PAD: l.word = BASE_W'(pad_byte);
            DEV_GUN_ONE: begin
                l.word  = BASE_W'(g1_trig);
                l.gun_x = g1_x;
                l.gun_y = g1_y;
            end
            DEV_GUN_TWO: begin
                l.word  = BASE_W'(g2_trig);
                l.gun_x = g2_x;
                l.gun_y = g2_y;
            end
            DEV_PADDLE: begin
                if (paddle_ok) begin
                    l.word = BASE_W'(paddle_sum ^ PADDLE_INVERT);
                end
            end
            default: l = '0;
        endcase
        return l;
    endfunction

    // Latch both ports and merge in the extension pads and their signature bits
    always_comb begin
        latch_zero = latch_port(nib0, i_pad_buttons[7:0], 1'b0,
                                i_gun_one_trigger, i_gun_one_x, i_gun_one_y,
                                i_gun_two_trigger, i_gun_two_x, i_gun_two_y,
                                i_paddle_position);
        latch_one  = latch_port(nib1, i_pad_buttons[15:8], 1'b1,
                                i_gun_one_trigger, i_gun_one_x, i_gun_one_y,
                                i_gun_two_trigger, i_gun_two_x, i_gun_two_y,
                                i_paddle_position);
        if (nib2 != DEV_NONE) begin
            if (nib2 == DEV_PAD) begin
                latch_zero.word[15:8] = latch_zero.word[15:8] | i_pad_buttons[23:16];
            end
            latch_zero.word[SIG_ZERO_BIT] = 1'b1;
        end
        if (nib3 != DEV_NONE) begin
            if (nib3 == DEV_PAD) begin
                latch_one.word[15:8] = latch_one.word[15:8] | i_pad_buttons[31:24];
            end
            latch_one.word[SIG_ONE_BIT] = 1'b1;
        end
        n_serial_zero = SERIAL_BITS'(latch_zero.word);
        n_serial_one  = SERIAL_BITS'(latch_one.word);
    end

    // Form the read byte for the addressed port
    always_comb begin
        sel_word  = is_read_one ? r_serial_one : r_serial_zero;
        sel_count = is_read_one ? r_count_one : r_count_zero;
        sel_gun   = is_read_one ? (nib1 == DEV_GUN_TWO) : (nib0 == DEV_GUN_ONE);
        pal       = {1'b0, r_palette_base};
        bright    = (i_pixel_at_gun == pal + BRIGHT_A) || (i_pixel_at_gun == pal + BRIGHT_B)
                 || (i_pixel_at_gun == pal + BRIGHT_C) || (i_pixel_at_gun == pal + BRIGHT_D);
        if (sel_count < t_count'(SERIAL_BITS)) begin
            serial_bit = sel_word[sel_count[IDX_W-1:0]];
            n_count    = sel_count + t_count'(1);
        end else begin
            serial_bit = 1'b0;
            n_count    = sel_count;
        end
        n_read_data    = READ_BASE;
        n_read_data[0] = serial_bit;
        if (sel_gun) begin
            n_read_data[LIGHT_BIT]   = ~bright;
            n_read_data[TRIGGER_BIT] = sel_word[0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_select <= '0;
            r_palette_base  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_SELECT: r_device_select <= i_cfg_data;
                CFG_PALETTE_BASE:  r_palette_base  <= i_cfg_data[7:0];
                default:           r_palette_base  <= r_palette_base;
            endcase
        end
    end

    // Port state: latch on strobe, advance counters on reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial_zero <= '0;
            r_serial_one  <= '0;
            r_count_zero  <= '0;
            r_count_one   <= '0;
            r_gun_x_zero  <= '0;
            r_gun_y_zero  <= '0;
            r_gun_x_one   <= '0;
            r_gun_y_one   <= '0;
        end else if (accept) begin
            if (is_strobe) begin
                r_serial_zero <= n_serial_zero;
                r_serial_one  <= n_serial_one;
                r_count_zero  <= '0;
                r_count_one   <= '0;
                r_gun_x_zero  <= latch_zero.gun_x;
                r_gun_y_zero  <= latch_zero.gun_y;
                r_gun_x_one   <= latch_one.gun_x;
                r_gun_y_one   <= latch_one.gun_y;
            end else if (is_read_zero) begin
                r_count_zero <= n_count;
            end else if (is_read_one) begin
                r_count_one <= n_count;
            end
        end
    end

    // Result register: load on a read transfer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (is_read_zero || is_read_one)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (is_read_zero || is_read_one)) begin
            r_read_data <= n_read_data;
            r_gun_x     <= is_read_one ? r_gun_x_one : r_gun_x_zero;
            r_gun_y     <= is_read_one ? r_gun_y_one : r_gun_y_zero;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_latched_gun_x = r_gun_x;
    assign o_latched_gun_y = r_gun_y;

endmodule
